>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the calculator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// Check that cond is never true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> hw/rtl/kcalc_pkg.sv
// Package for the keypad calculator: word types, codes, widths and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package kcalc_pkg;

	localparam int OPERAND_W = 17;
	localparam int LIMIT_W   = 16;
	localparam int RES_W     = 35;
	localparam int DIV_STEPS = 17;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int ENTRY_W   = 21;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

	// key kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_OP    = 2'd1;
	localparam logic [1:0] KIND_DIGIT = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	// operator key values
	localparam logic [3:0] KEY_ADD    = 4'd1;
	localparam logic [3:0] KEY_DIV    = 4'd4;
	localparam logic [3:0] KEY_EQUALS = 4'd5;
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;

	// stored operator codes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// phases
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_DIVZERO  = 2'd2;
	localparam logic [1:0] ERR_UNUSED   = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] value;
	} kcalc_in_t;

	typedef struct packed {
		logic signed [OPERAND_W-1:0] display_value;
		logic [1:0]                  error;
		logic [1:0]                  phase;
	} kcalc_out_t;

	typedef struct packed {
		logic load_key;
		logic start_calc;
		logic div_step;
		logic commit;
	} kcalc_cmd_t;

	typedef struct packed {
		logic need_calc;
		logic div_run;
	} kcalc_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/kcalc_ctrl.sv
// Controller state machine of the keypad calculator.
// Depends on kcalc_pkg; drives datapath commands from its status.
`default_nettype none

module kcalc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	input  kcalc_pkg::kcalc_sts_t  sts,
	output kcalc_pkg::kcalc_cmd_t  cmd
);
	import kcalc_pkg::*;

	localparam logic [1:0] ST_READY = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_ARITH = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]       state_q, state_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             out_valid_q, out_valid_n;
	logic             slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_READY);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		cnt_n   = cnt_q;
		unique case (state_q)
			ST_READY: begin
				if (in_valid) begin
					cmd.load_key = 1'b1;
					state_n      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.need_calc) begin
					cmd.start_calc = 1'b1;
					if (sts.div_run) begin
						cnt_n   = CNT_W'(DIV_STEPS - 1);
						state_n = ST_ARITH;
					end else begin
						state_n = ST_FIN;
					end
				end else if (slot_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_READY;
				end
			end
			ST_ARITH: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_n = ST_FIN;
				end else begin
					cnt_n = cnt_q - 1'b1;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_READY;
				end
			end
			default: begin
				state_n = ST_READY;
			end
		endcase
	end

	always_comb begin
		if (cmd.commit) begin
			out_valid_n = 1'b1;
		end else if (out_ready) begin
			out_valid_n = 1'b0;
		end else begin
			out_valid_n = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			cnt_q       <= cnt_n;
			out_valid_q <= out_valid_n;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/kcalc_dp.sv
// Datapath of the keypad calculator: operand and result registers, limit,
// adder/multiplier, restoring divider and output word. Depends on kcalc_pkg.
`default_nettype none

module kcalc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kcalc_pkg::kcalc_cmd_t         cmd,
	output kcalc_pkg::kcalc_sts_t         sts,
	input  kcalc_pkg::kcalc_in_t          key_in,
	input  logic                          limit_we,
	input  logic [kcalc_pkg::LIMIT_W-1:0] limit_wdata,
	output kcalc_pkg::kcalc_out_t         out_word
);
	import kcalc_pkg::*;

	logic [LIMIT_W-1:0]          limit_q;
	logic [1:0]                  phase_q, phase_n;
	logic signed [OPERAND_W-1:0] first_q, first_n;
	logic [1:0]                  op_q, op_n;
	logic [LIMIT_W-1:0]          second_q, second_n;
	logic signed [OPERAND_W-1:0] last_q, last_n;
	logic                        rvalid_q, rvalid_n;
	logic [1:0]                  err_n;
	logic signed [OPERAND_W-1:0] shown_n;

	kcalc_in_t                   key_q;
	kcalc_out_t                  out_q;

	logic signed [RES_W-1:0]     res_q, res_n;
	logic [LIMIT_W-1:0]          rem_q;
	logic [OPERAND_W-1:0]        quo_q;

	logic is_digit, is_op, is_eq, is_clr;

	assign is_digit = (key_q.kind == KIND_DIGIT) && (key_q.value <= KEY_DIGIT_MAX);
	assign is_op    = (key_q.kind == KIND_OP) && (key_q.value >= KEY_ADD)
	               && (key_q.value <= KEY_DIV);
	assign is_eq    = (key_q.kind == KIND_OP) && (key_q.value == KEY_EQUALS);
	assign is_clr   = (key_q.kind == KIND_CLEAR);

	assign sts.need_calc = is_eq && (phase_q == PH_SECOND);
	assign sts.div_run   = (op_q == OP_DIV) && (second_q != '0);

	// add, subtract and multiply, registered at start
	logic signed [RES_W-1:0]       a_ext, b_ext;
	logic signed [2*OPERAND_W-1:0] prod;
	logic [OPERAND_W-1:0]          a_mag;

	assign a_ext = RES_W'(first_q);
	assign b_ext = $signed({{(RES_W-LIMIT_W){1'b0}}, second_q});
	assign prod  = (2*OPERAND_W)'(first_q) * (2*OPERAND_W)'($signed({1'b0, second_q}));
	assign a_mag = first_q[OPERAND_W-1] ? OPERAND_W'(-first_q) : OPERAND_W'(first_q);

	always_comb begin
		unique case (op_q)
			OP_ADD:  res_n = a_ext + b_ext;
			OP_SUB:  res_n = a_ext - b_ext;
			OP_MUL:  res_n = RES_W'(prod);
			default: res_n = '0;
		endcase
	end

	// restoring division step: one quotient bit per cycle
	logic [OPERAND_W-1:0] trial;
	logic                 ge;

	assign trial = {rem_q, quo_q[OPERAND_W-1]};
	assign ge    = trial >= {1'b0, second_q};

	always_ff @(posedge clk) begin
		if (cmd.start_calc) begin
			res_q <= res_n;
			rem_q <= '0;
			quo_q <= a_mag;
		end else if (cmd.div_step) begin
			rem_q <= ge ? LIMIT_W'(trial - {1'b0, second_q}) : trial[LIMIT_W-1:0];
			quo_q <= {quo_q[OPERAND_W-2:0], ge};
		end
	end

	// result selection and range check
	logic signed [RES_W-1:0] q_ext, calc_val, lim_s;
	logic                    in_range;
	logic [1:0]              calc_err;

	assign q_ext    = $signed({{(RES_W-OPERAND_W){1'b0}}, quo_q});
	assign calc_val = (op_q == OP_DIV) ? (first_q[OPERAND_W-1] ? -q_ext : q_ext) : res_q;
	assign lim_s    = $signed({{(RES_W-LIMIT_W){1'b0}}, limit_q});
	assign in_range = (calc_val <= lim_s) && (calc_val >= ~lim_s);

	always_comb begin
		if ((op_q == OP_DIV) && (second_q == '0)) begin
			calc_err = ERR_DIVZERO;
		end else if (!in_range) begin
			calc_err = ERR_OVERFLOW;
		end else begin
			calc_err = ERR_NONE;
		end
	end

	// digit accumulation
	logic [ENTRY_W-1:0] n_first, n_second, lim_e;

	assign lim_e    = {{(ENTRY_W-LIMIT_W){1'b0}}, limit_q};
	assign n_first  = {{(ENTRY_W-OPERAND_W){1'b0}}, first_q} * ENTRY_W'(10)
	                + {{(ENTRY_W-4){1'b0}}, key_q.value};
	assign n_second = {{(ENTRY_W-LIMIT_W){1'b0}}, second_q} * ENTRY_W'(10)
	                + {{(ENTRY_W-4){1'b0}}, key_q.value};

	always_comb begin
		phase_n  = phase_q;
		first_n  = first_q;
		op_n     = op_q;
		second_n = second_q;
		last_n   = last_q;
		rvalid_n = rvalid_q;
		err_n    = ERR_NONE;
		unique case (phase_q)
			PH_FIRST: begin
				if (is_digit) begin
					if (n_first > lim_e) begin
						err_n    = ERR_OVERFLOW;
						phase_n  = PH_IDLE;
						first_n  = '0;
						second_n = '0;
						op_n     = OP_ADD;
					end else begin
						first_n = $signed(n_first[OPERAND_W-1:0]);
					end
				end else if (is_clr) begin
					phase_n  = PH_IDLE;
					first_n  = '0;
					second_n = '0;
					op_n     = OP_ADD;
				end else if (is_op) begin
					op_n     = 2'(key_q.value - KEY_ADD);
					second_n = '0;
					phase_n  = PH_SECOND;
				end
			end
			PH_SECOND: begin
				if (is_digit) begin
					if (n_second > lim_e) begin
						err_n    = ERR_OVERFLOW;
						phase_n  = PH_IDLE;
						first_n  = '0;
						second_n = '0;
						op_n     = OP_ADD;
					end else begin
						second_n = n_second[LIMIT_W-1:0];
					end
				end else if (is_clr || is_eq) begin
					if (is_eq) begin
						err_n = calc_err;
						if (calc_err == ERR_NONE) begin
							last_n   = calc_val[OPERAND_W-1:0];
							rvalid_n = 1'b1;
						end
					end
					phase_n  = PH_IDLE;
					first_n  = '0;
					second_n = '0;
					op_n     = OP_ADD;
				end
			end
			default: begin
				phase_n  = PH_IDLE;
				first_n  = '0;
				second_n = '0;
				op_n     = OP_ADD;
				if (is_digit) begin
					if ({{(LIMIT_W-4){1'b0}}, key_q.value} > limit_q) begin
						err_n = ERR_OVERFLOW;
					end else begin
						first_n = $signed({{(OPERAND_W-4){1'b0}}, key_q.value});
						phase_n = PH_FIRST;
					end
				end else if (is_clr) begin
					last_n = '0;
				end else if (is_op && rvalid_q) begin
					first_n = last_q;
					op_n    = 2'(key_q.value - KEY_ADD);
					phase_n = PH_SECOND;
				end
			end
		endcase
	end

	always_comb begin
		unique case (phase_n)
			PH_FIRST:  shown_n = first_n;
			PH_SECOND: shown_n = $signed({1'b0, second_n});
			default:   shown_n = last_n;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			phase_q  <= PH_FIRST;
			first_q  <= '0;
			op_q     <= OP_ADD;
			second_q <= '0;
			last_q   <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_wdata;
			end
			if (cmd.commit) begin
				phase_q  <= phase_n;
				first_q  <= first_n;
				op_q     <= op_n;
				second_q <= second_n;
				last_q   <= last_n;
				rvalid_q <= rvalid_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= key_in;
		end
		if (cmd.commit) begin
			out_q.display_value <= shown_n;
			out_q.error         <= err_n;
			out_q.phase         <= phase_n;
		end
	end

	assign out_word = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/keypad_calculator_fsm_core.sv
// Keypad calculator top level: one key word in, one display word out.
// Each key is accepted, then committed to the display word. Equals in
// second-operand entry first starts the calculation; divide by a nonzero
// operand then runs the 17 divider steps before the commit.
// A key is accepted only after the previous one is committed; a held output word stalls the commit.
// Reset (arst_n low, asynchronous): first-operand entry, operands and last
// result zero, no valid result, limit 65535, no output word pending.
`default_nettype none
`include "assert_macros.svh"

module keypad_calculator_fsm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// key channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  kcalc_pkg::kcalc_in_t          in_data,
	// display channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output kcalc_pkg::kcalc_out_t         out_data,
	// limit register write
	input  logic                          limit_we,
	input  logic [kcalc_pkg::LIMIT_W-1:0] limit_wdata
);
	import kcalc_pkg::*;

	kcalc_cmd_t cmd;
	kcalc_sts_t sts;

	// Controller: accept one key, then either commit it directly or run the
	// arithmetic (a registered start, then for divide by a nonzero operand the
	// 17 divider steps) and commit in the finish state. A commit waits until the
	// output register is free, so a delivered word is never overwritten; the next
	// key is taken while the previous word still waits on out_ready.
	kcalc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: holds the key, operands, last result and the limit; builds
	// the next calculator state and the display word on commit.
	kcalc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.key_in      (in_data),
		.limit_we    (limit_we),
		.limit_wdata (limit_wdata),
		.out_word    (out_data)
	);

	// Never overwrite a pending output word.
	`ASSERT_PROP(a_commit_slot, clk, arst_n, cmd.commit |-> (!out_valid || out_ready))
	// Commit never falls in the key-accept cycle.
	`ASSERT_NEVER(a_commit_ready, clk, arst_n, in_ready && cmd.commit)
	// Hold the calculation start away from the accept cycle too.
	`ASSERT_NEVER(a_start_ready, clk, arst_n, in_ready && cmd.start_calc)
	// A shown word never carries the unused phase or error code.
	`ASSERT_NEVER(a_out_codes, clk, arst_n,
		out_valid && (out_data.phase == PH_UNUSED || out_data.error == ERR_UNUSED))

endmodule

`default_nettype wire
